// ===== hw/rtl/rvex_pkg.sv =====
package rvex_pkg;

    localparam int NumCells = 64;

    // operation codes
    localparam logic [5:0] OpBeq    = 6'd0;
    localparam logic [5:0] OpBne    = 6'd1;
    localparam logic [5:0] OpBlt    = 6'd2;
    localparam logic [5:0] OpBge    = 6'd3;
    localparam logic [5:0] OpBltu   = 6'd4;
    localparam logic [5:0] OpBgeu   = 6'd5;
    localparam logic [5:0] OpJal    = 6'd6;
    localparam logic [5:0] OpJalr   = 6'd7;
    localparam logic [5:0] OpLui    = 6'd8;
    localparam logic [5:0] OpAuipc  = 6'd9;
    localparam logic [5:0] OpAdd    = 6'd10;
    localparam logic [5:0] OpSub    = 6'd11;
    localparam logic [5:0] OpSll    = 6'd12;
    localparam logic [5:0] OpSlt    = 6'd13;
    localparam logic [5:0] OpSltu   = 6'd14;
    localparam logic [5:0] OpXor    = 6'd15;
    localparam logic [5:0] OpSrl    = 6'd16;
    localparam logic [5:0] OpSra    = 6'd17;
    localparam logic [5:0] OpOr     = 6'd18;
    localparam logic [5:0] OpAnd    = 6'd19;
    localparam logic [5:0] OpMul    = 6'd20;
    localparam logic [5:0] OpMulh   = 6'd21;
    localparam logic [5:0] OpMulhsu = 6'd22;
    localparam logic [5:0] OpMulhu  = 6'd23;
    localparam logic [5:0] OpDiv    = 6'd24;
    localparam logic [5:0] OpDivu   = 6'd25;
    localparam logic [5:0] OpRem    = 6'd26;
    localparam logic [5:0] OpRemu   = 6'd27;
    localparam logic [5:0] OpAddw   = 6'd28;
    localparam logic [5:0] OpSubw   = 6'd29;
    localparam logic [5:0] OpSllw   = 6'd30;
    localparam logic [5:0] OpSrlw   = 6'd31;
    localparam logic [5:0] OpSraw   = 6'd32;
    localparam logic [5:0] OpMulw   = 6'd33;
    localparam logic [5:0] OpDivw   = 6'd34;
    localparam logic [5:0] OpDivuw  = 6'd35;
    localparam logic [5:0] OpRemw   = 6'd36;
    localparam logic [5:0] OpRemuw  = 6'd37;
    localparam logic [5:0] OpAddiw  = 6'd38;
    localparam logic [5:0] OpSlliw  = 6'd39;
    localparam logic [5:0] OpSrliw  = 6'd40;
    localparam logic [5:0] OpSraiw  = 6'd41;
    localparam logic [5:0] OpAddi   = 6'd42;
    localparam logic [5:0] OpSlli   = 6'd43;
    localparam logic [5:0] OpSlti   = 6'd44;
    localparam logic [5:0] OpSltiu  = 6'd45;
    localparam logic [5:0] OpXori   = 6'd46;
    localparam logic [5:0] OpSrli   = 6'd47;
    localparam logic [5:0] OpSrai   = 6'd48;
    localparam logic [5:0] OpOri    = 6'd49;
    localparam logic [5:0] OpAndi   = 6'd50;

    // fields that ride along the chain untouched
    typedef struct packed {
        logic [5:0]  op;
        logic [63:0] value;
        logic        redirect;
        logic [63:0] target;
        logic [63:0] corr;
        logic        q_neg;
        logic        r_neg;
    } side_t;

    // multiply / divide working state, one step per cell
    typedef struct packed {
        logic [63:0] acc;
        logic [63:0] shreg;
        logic [63:0] opnd;
        logic        is_div;
    } work_t;

    function automatic logic [63:0] sx32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

// ===== hw/rtl/rvex_front.sv =====
module rvex_front (
    input  logic [5:0]         op,
    input  logic [63:0]        inst_pc,
    input  logic [63:0]        src_a,
    input  logic [63:0]        src_b,
    input  logic signed [31:0] immediate,
    output rvex_pkg::side_t    side,
    output rvex_pkg::work_t    work
);

    always_comb
    begin
        logic [63:0] imm;
        logic [63:0] seq;
        logic [63:0] upper;
        logic [63:0] aw;
        logic [63:0] bw;
        logic [5:0]  sh;
        logic [4:0]  shw;
        logic [5:0]  ish;
        logic [4:0]  ishw;
        logic        take;
        logic        is_w;
        logic        is_signed;
        logic [63:0] da;
        logic [63:0] db;
        logic        na;
        logic        nb;

        imm   = {{32{immediate[31]}}, immediate};
        seq   = inst_pc + 64'd4;
        upper = {{32{immediate[19]}}, immediate[19:0], 12'b0};
        aw    = rvex_pkg::sx32(src_a);
        bw    = rvex_pkg::sx32(src_b);
        sh    = src_b[5:0];
        shw   = src_b[4:0];
        ish   = imm[5:0];
        ishw  = imm[4:0];
        take  = 1'b0;

        side.op       = op;
        side.value    = '0;
        side.redirect = 1'b0;
        side.target   = seq;
        side.corr     = '0;
        side.q_neg    = 1'b0;
        side.r_neg    = 1'b0;

        // plain alu, branch and jump ops
        unique case (op)
            rvex_pkg::OpBeq:   take = (src_a == src_b);
            rvex_pkg::OpBne:   take = (src_a != src_b);
            rvex_pkg::OpBlt:   take = ($signed(src_a) < $signed(src_b));
            rvex_pkg::OpBge:   take = !($signed(src_a) < $signed(src_b));
            rvex_pkg::OpBltu:  take = (src_a < src_b);
            rvex_pkg::OpBgeu:  take = (src_a >= src_b);
            rvex_pkg::OpJal:
            begin
                side.value    = seq;
                side.redirect = 1'b1;
                side.target   = inst_pc + imm;
            end
            rvex_pkg::OpJalr:
            begin
                side.value    = seq;
                side.redirect = 1'b1;
                side.target   = (src_a + imm) & ~64'd1;
            end
            rvex_pkg::OpLui:   side.value = upper;
            rvex_pkg::OpAuipc: side.value = inst_pc + upper;
            rvex_pkg::OpAdd:   side.value = src_a + src_b;
            rvex_pkg::OpSub:   side.value = src_a - src_b;
            rvex_pkg::OpSll:   side.value = src_a << sh;
            rvex_pkg::OpSlt:   side.value = {63'b0, $signed(src_a) < $signed(src_b)};
            rvex_pkg::OpSltu:  side.value = {63'b0, src_a < src_b};
            rvex_pkg::OpXor:   side.value = src_a ^ src_b;
            rvex_pkg::OpSrl:   side.value = src_a >> sh;
            rvex_pkg::OpSra:   side.value = $unsigned($signed(src_a) >>> sh);
            rvex_pkg::OpOr:    side.value = src_a | src_b;
            rvex_pkg::OpAnd:   side.value = src_a & src_b;
            rvex_pkg::OpAddw:  side.value = rvex_pkg::sx32(src_a + src_b);
            rvex_pkg::OpSubw:  side.value = rvex_pkg::sx32(src_a - src_b);
            rvex_pkg::OpSllw:  side.value = rvex_pkg::sx32(src_a << shw);
            rvex_pkg::OpSrlw:  side.value = rvex_pkg::sx32({32'b0, src_a[31:0]} >> shw);
            rvex_pkg::OpSraw:  side.value = $unsigned($signed(aw) >>> shw);
            rvex_pkg::OpAddiw: side.value = rvex_pkg::sx32(src_a + imm);
            rvex_pkg::OpSlliw: side.value = rvex_pkg::sx32(src_a << ishw);
            rvex_pkg::OpSrliw: side.value = rvex_pkg::sx32({32'b0, src_a[31:0]} >> ishw);
            rvex_pkg::OpSraiw: side.value = $unsigned($signed(aw) >>> ishw);
            rvex_pkg::OpAddi:  side.value = src_a + imm;
            rvex_pkg::OpSlli:  side.value = src_a << ish;
            rvex_pkg::OpSlti:  side.value = {63'b0, $signed(src_a) < $signed(imm)};
            rvex_pkg::OpSltiu: side.value = {63'b0, src_a < imm};
            rvex_pkg::OpXori:  side.value = src_a ^ imm;
            rvex_pkg::OpSrli:  side.value = src_a >> ish;
            rvex_pkg::OpSrai:  side.value = $unsigned($signed(src_a) >>> ish);
            rvex_pkg::OpOri:   side.value = src_a | imm;
            rvex_pkg::OpAndi:  side.value = src_a & imm;
            default:           side.value = '0;
        endcase

        // taken branch
        if (op <= rvex_pkg::OpBgeu && take)
        begin
            side.redirect = 1'b1;
            side.target   = inst_pc + imm;
        end

        // high-product sign correction
        if (op == rvex_pkg::OpMulh)
        begin
            side.corr = (src_a[63] ? src_b : 64'd0) + (src_b[63] ? src_a : 64'd0);
        end
        else if (op == rvex_pkg::OpMulhsu)
        begin
            side.corr = src_a[63] ? src_b : 64'd0;
        end

        // divider operands
        is_w = (op == rvex_pkg::OpDivw) || (op == rvex_pkg::OpDivuw)
            || (op == rvex_pkg::OpRemw) || (op == rvex_pkg::OpRemuw);
        is_signed = (op == rvex_pkg::OpDiv) || (op == rvex_pkg::OpRem)
            || (op == rvex_pkg::OpDivw) || (op == rvex_pkg::OpRemw);
        if (is_signed)
        begin
            da = is_w ? aw : src_a;
            db = is_w ? bw : src_b;
        end
        else
        begin
            da = is_w ? {32'b0, src_a[31:0]} : src_a;
            db = is_w ? {32'b0, src_b[31:0]} : src_b;
        end
        na = is_signed && da[63];
        nb = is_signed && db[63];

        work.acc    = '0;
        work.shreg  = '0;
        work.opnd   = '0;
        work.is_div = 1'b0;
        if (op == rvex_pkg::OpMul || op == rvex_pkg::OpMulh || op == rvex_pkg::OpMulhsu
            || op == rvex_pkg::OpMulhu || op == rvex_pkg::OpMulw)
        begin
            work.shreg = src_b;
            work.opnd  = src_a;
        end
        else if (op == rvex_pkg::OpDiv || op == rvex_pkg::OpDivu || op == rvex_pkg::OpRem
            || op == rvex_pkg::OpRemu || is_w)
        begin
            work.shreg  = na ? (64'd0 - da) : da;
            work.opnd   = nb ? (64'd0 - db) : db;
            work.is_div = 1'b1;
            side.q_neg  = (na != nb) && (db != 64'd0);
            side.r_neg  = na;
        end
    end

endmodule

// ===== hw/rtl/rvex_cell.sv =====
module rvex_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  rvex_pkg::side_t in_side,
    input  rvex_pkg::work_t in_work,
    output logic            out_valid,
    output rvex_pkg::side_t out_side,
    output rvex_pkg::work_t out_work
);

    logic            valid_reg;
    rvex_pkg::side_t side_reg;
    rvex_pkg::work_t work_reg;
    rvex_pkg::work_t work_next;

    // one multiply bit (shift-add) or one quotient bit (restoring)
    always_comb
    begin
        logic [64:0] sum;
        logic [64:0] diff;
        logic [64:0] part;

        part = {in_work.acc, in_work.shreg[63]};
        diff = part - {1'b0, in_work.opnd};
        sum  = {1'b0, in_work.acc} + (in_work.shreg[0] ? {1'b0, in_work.opnd} : 65'd0);

        work_next = in_work;
        if (in_work.is_div)
        begin
            if (!diff[64])
            begin
                work_next.acc = diff[63:0];
            end
            else
            begin
                work_next.acc = part[63:0];
            end
            work_next.shreg = {in_work.shreg[62:0], !diff[64]};
        end
        else
        begin
            work_next.acc   = sum[64:1];
            work_next.shreg = {sum[0], in_work.shreg[63:1]};
        end
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= in_side;
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_work  = work_reg;

endmodule

// ===== hw/rtl/rvex_back.sv =====
module rvex_back (
    input  rvex_pkg::side_t side,
    input  rvex_pkg::work_t work,
    output logic [63:0]     value
);

    always_comb
    begin
        logic [63:0] quo;
        logic [63:0] rem;

        quo = side.q_neg ? (64'd0 - work.shreg) : work.shreg;
        rem = side.r_neg ? (64'd0 - work.acc) : work.acc;

        // pick the multiply / divide result, or the early alu value
        unique case (side.op)
            rvex_pkg::OpMul:    value = work.shreg;
            rvex_pkg::OpMulh:   value = work.acc - side.corr;
            rvex_pkg::OpMulhsu: value = work.acc - side.corr;
            rvex_pkg::OpMulhu:  value = work.acc;
            rvex_pkg::OpMulw:   value = rvex_pkg::sx32(work.shreg);
            rvex_pkg::OpDiv:    value = quo;
            rvex_pkg::OpDivu:   value = quo;
            rvex_pkg::OpRem:    value = rem;
            rvex_pkg::OpRemu:   value = rem;
            rvex_pkg::OpDivw:   value = rvex_pkg::sx32(quo);
            rvex_pkg::OpDivuw:  value = rvex_pkg::sx32(quo);
            rvex_pkg::OpRemw:   value = rvex_pkg::sx32(rem);
            rvex_pkg::OpRemuw:  value = rvex_pkg::sx32(rem);
            default:            value = side.value;
        endcase
    end

endmodule

// ===== hw/rtl/rv64im_execute_unit.sv =====
// path: an accepted input item passes through the input stage, 64 cells and the
// output stage to its result
// throughput: one item per cycle unless a held result stalls the chain; every op walks
// the same 64-cell chain, each cell doing one multiply bit or one quotient bit
// a stalled output that holds a valid result freezes the whole chain
// reset: asynchronous, active low, clears all valid bits; no other state
module rv64im_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [5:0]         op,
    input  logic [63:0]        inst_pc,
    input  logic [63:0]        src_a,
    input  logic [63:0]        src_b,
    input  logic signed [31:0] immediate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [63:0]        result_value,
    output logic               redirect,
    output logic [63:0]        target_pc
);

    logic            advance;
    rvex_pkg::side_t front_side;
    rvex_pkg::work_t front_work;
    logic            in_valid_reg;
    rvex_pkg::side_t in_side_reg;
    rvex_pkg::work_t in_work_reg;
    logic            chain_valid [rvex_pkg::NumCells+1];
    rvex_pkg::side_t chain_side  [rvex_pkg::NumCells+1];
    rvex_pkg::work_t chain_work  [rvex_pkg::NumCells+1];
    logic [63:0]     back_value;
    logic            out_valid_reg;
    logic [63:0]     result_reg;
    logic            redirect_reg;
    logic [63:0]     target_reg;

    // whole chain moves unless a finished result is held
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    rvex_front u_front (
        .op        (op),
        .inst_pc   (inst_pc),
        .src_a     (src_a),
        .src_b     (src_b),
        .immediate (immediate),
        .side      (front_side),
        .work      (front_work)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_side_reg <= front_side;
            in_work_reg <= front_work;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_side[0]  = in_side_reg;
    assign chain_work[0]  = in_work_reg;

    // cell chain
    for (genvar i = 0; i < rvex_pkg::NumCells; i++)
    begin : g_cell
        rvex_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_side   (chain_side[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_side  (chain_side[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    rvex_back u_back (
        .side  (chain_side[rvex_pkg::NumCells]),
        .work  (chain_work[rvex_pkg::NumCells]),
        .value (back_value)
    );

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[rvex_pkg::NumCells];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg   <= back_value;
            redirect_reg <= chain_side[rvex_pkg::NumCells].redirect;
            target_reg   <= chain_side[rvex_pkg::NumCells].target;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign redirect     = redirect_reg;
    assign target_pc    = target_reg;

`ifndef SYNTHESIS
    // last cell item lands in the output stage
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance && chain_valid[rvex_pkg::NumCells] |=> out_valid_reg)
        else $error("item lost between last cell and output stage");

    // a held result freezes the chain
    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain_valid[rvex_pkg::NumCells / 2]) && $stable(in_valid_reg))
        else $error("chain moved while output held");

    // entry stage valid follows input when moving
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid |=> in_valid_reg)
        else $error("accepted item missing from entry stage");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [5:0]         op;
    logic [63:0]        inst_pc;
    logic [63:0]        src_a;
    logic [63:0]        src_b;
    logic signed [31:0] immediate;
    logic               out_valid;
    logic               out_stall;
    logic [63:0]        result_value;
    logic               redirect;
    logic [63:0]        target_pc;

    typedef struct packed {
        logic [63:0] value;
        logic        redir;
        logic [63:0] target;
    } exec_result_t;

    localparam logic [5:0]  OpLdst = 6'd51;
    localparam logic [63:0] Ones64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Sign64 = 64'h8000_0000_0000_0000;
    localparam int          Latency = 65;
    localparam int          IdleLimit = 4000;

    exec_result_t expected_results[$];
    int  mismatches;
    int  idle_pct;
    int  hold_cycles;
    bit  timed_out;

    rv64im_execute_unit dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] sext32(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic signed_lt(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // signed divide with the zero and overflow rules
    function automatic logic [63:0] sdiv(input logic [63:0] a, input logic [63:0] b,
                                         input bit want_rem);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        logic [63:0] r;
        if (b == 64'd0)
            return want_rem ? a : Ones64;
        if (a == Sign64 && b == Ones64)
            return want_rem ? 64'd0 : a;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        r = ua % ub;
        if (a[63] != b[63])
            q = -q;
        if (a[63])
            r = -r;
        return want_rem ? r : q;
    endfunction

    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b,
                                         input bit want_rem);
        if (b == 64'd0)
            return want_rem ? a : Ones64;
        return want_rem ? a % b : a / b;
    endfunction

    // computes the execute result of one instruction
    function automatic exec_result_t execute_op(input logic [5:0] code,
                                                input logic [63:0] pc,
                                                input logic [63:0] a,
                                                input logic [63:0] b,
                                                input logic [31:0] imm32);
        exec_result_t res;
        logic [63:0]  imm;
        logic [63:0]  upper;
        logic [63:0]  aw;
        logic [63:0]  bw;
        logic [127:0] prod;
        logic         take;
        imm   = {{32{imm32[31]}}, imm32};
        upper = sext32({imm32, 12'd0});
        aw    = sext32(a);
        bw    = sext32(b);
        take  = 1'b0;
        res.value  = 64'd0;
        res.redir  = 1'b0;
        res.target = pc + 64'd4;
        case (code)
            rvex_pkg::OpBeq:    take = (a == b);
            rvex_pkg::OpBne:    take = (a != b);
            rvex_pkg::OpBlt:    take = signed_lt(a, b);
            rvex_pkg::OpBge:    take = !signed_lt(a, b);
            rvex_pkg::OpBltu:   take = (a < b);
            rvex_pkg::OpBgeu:   take = (a >= b);
            rvex_pkg::OpJal:
            begin
                res.value = pc + 64'd4;
                res.redir = 1'b1;
                res.target = pc + imm;
            end
            rvex_pkg::OpJalr:
            begin
                res.value = pc + 64'd4;
                res.redir = 1'b1;
                res.target = (a + imm) & ~64'd1;
            end
            rvex_pkg::OpLui:    res.value = upper;
            rvex_pkg::OpAuipc:  res.value = pc + upper;
            rvex_pkg::OpAdd:    res.value = a + b;
            rvex_pkg::OpSub:    res.value = a - b;
            rvex_pkg::OpSll:    res.value = a << b[5:0];
            rvex_pkg::OpSlt:    res.value = {63'd0, signed_lt(a, b)};
            rvex_pkg::OpSltu:   res.value = {63'd0, a < b};
            rvex_pkg::OpXor:    res.value = a ^ b;
            rvex_pkg::OpSrl:    res.value = a >> b[5:0];
            rvex_pkg::OpSra:    res.value = $signed(a) >>> b[5:0];
            rvex_pkg::OpOr:     res.value = a | b;
            rvex_pkg::OpAnd:    res.value = a & b;
            rvex_pkg::OpMul:    res.value = a * b;
            rvex_pkg::OpMulh:
            begin
                prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                res.value = prod[127:64];
            end
            rvex_pkg::OpMulhsu:
            begin
                prod = {{64{a[63]}}, a} * {64'd0, b};
                res.value = prod[127:64];
            end
            rvex_pkg::OpMulhu:
            begin
                prod = {64'd0, a} * {64'd0, b};
                res.value = prod[127:64];
            end
            rvex_pkg::OpDiv:    res.value = sdiv(a, b, 1'b0);
            rvex_pkg::OpDivu:   res.value = udiv(a, b, 1'b0);
            rvex_pkg::OpRem:    res.value = sdiv(a, b, 1'b1);
            rvex_pkg::OpRemu:   res.value = udiv(a, b, 1'b1);
            rvex_pkg::OpAddw:   res.value = sext32(a + b);
            rvex_pkg::OpSubw:   res.value = sext32(a - b);
            rvex_pkg::OpSllw:   res.value = sext32(a << b[4:0]);
            rvex_pkg::OpSrlw:   res.value = sext32({32'd0, a[31:0]} >> b[4:0]);
            rvex_pkg::OpSraw:   res.value = $signed(aw) >>> b[4:0];
            rvex_pkg::OpMulw:   res.value = sext32(a * b);
            rvex_pkg::OpDivw:   res.value = sext32(sdiv(aw, bw, 1'b0));
            rvex_pkg::OpDivuw:
                res.value = sext32(udiv({32'd0, a[31:0]}, {32'd0, b[31:0]}, 1'b0));
            rvex_pkg::OpRemw:   res.value = sext32(sdiv(aw, bw, 1'b1));
            rvex_pkg::OpRemuw:
                res.value = sext32(udiv({32'd0, a[31:0]}, {32'd0, b[31:0]}, 1'b1));
            rvex_pkg::OpAddiw:  res.value = sext32(a + imm);
            rvex_pkg::OpSlliw:  res.value = sext32(a << imm[4:0]);
            rvex_pkg::OpSrliw:  res.value = sext32({32'd0, a[31:0]} >> imm[4:0]);
            rvex_pkg::OpSraiw:  res.value = $signed(aw) >>> imm[4:0];
            rvex_pkg::OpAddi:   res.value = a + imm;
            rvex_pkg::OpSlli:   res.value = a << imm[5:0];
            rvex_pkg::OpSlti:   res.value = {63'd0, signed_lt(a, imm)};
            rvex_pkg::OpSltiu:  res.value = {63'd0, a < imm};
            rvex_pkg::OpXori:   res.value = a ^ imm;
            rvex_pkg::OpSrli:   res.value = a >> imm[5:0];
            rvex_pkg::OpSrai:   res.value = $signed(a) >>> imm[5:0];
            rvex_pkg::OpOri:    res.value = a | imm;
            rvex_pkg::OpAndi:   res.value = a & imm;
            default:            res.value = 64'd0;
        endcase
        if (code <= rvex_pkg::OpBgeu && take)
        begin
            res.redir = 1'b1;
            res.target = pc + imm;
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // operand with a bias toward corner values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return Ones64;
            2: return Sign64;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return sext32({32'd0, $urandom()});
            5: return {32'd0, $urandom()};
            6: return 64'($urandom_range(0, 70));
            default: return rand64();
        endcase
    endfunction

    function automatic logic idle_now();
        return $urandom_range(0, 99) < idle_pct;
    endfunction

    // send one item and record its expected result
    task automatic send_item(input logic [5:0] code, input logic [63:0] pc,
                             input logic [63:0] a, input logic [63:0] b,
                             input logic [31:0] imm32);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        inst_pc   <= pc;
        src_a     <= a;
        src_b     <= b;
        immediate <= imm32;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(execute_op(code, pc, a, b, imm32));
    endtask

    task automatic send_random_item();
        logic [5:0] code;
        code = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(51, 63))
                                             : 6'($urandom_range(0, 50));
        send_item(code, rand64(), pick_operand(), pick_operand(),
                  ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 70)) - 32'd6
                                              : $urandom());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // extremes, every op, divide corner cases
    task automatic test_directed();
        logic [5:0] code;
        for (int i = 0; i <= 63; i++)
        begin
            code = 6'(i);
            send_item(code, Ones64 - 64'd2, Sign64, Ones64, 32'h8000_0000);
        end
        send_item(rvex_pkg::OpDiv, 64'd0, 64'h1234, 64'd0, 32'h7FFF_FFFF);
        send_item(rvex_pkg::OpRem, 64'd0, 64'h1234, 64'd0, 32'd0);
        send_item(rvex_pkg::OpDivu, 64'd0, 64'h1234, 64'd0, 32'd0);
        send_item(rvex_pkg::OpRemu, 64'd0, 64'h1234, 64'd0, 32'd0);
        send_item(rvex_pkg::OpDivw, 64'd0, 64'h8000_0000, 64'hFFFF_FFFF, 32'd0);
        send_item(rvex_pkg::OpRemw, 64'd0, 64'h8000_0000, 64'hFFFF_FFFF, 32'd0);
        send_item(rvex_pkg::OpDivuw, 64'd0, 64'h8000_0000, 64'h1_0000_0000, 32'd0);
        send_item(rvex_pkg::OpRemw, 64'd0, 64'h8000_0000, 64'h1_0000_0000, 32'd0);
        send_item(rvex_pkg::OpDiv, 64'd0, Sign64, Ones64, 32'd0);
        send_item(rvex_pkg::OpRem, 64'd0, Sign64, Ones64, 32'd0);
        send_item(rvex_pkg::OpJalr, 64'd0, Ones64, 64'd0, 32'h7FFF_FFFF);
        send_item(rvex_pkg::OpBeq, Ones64, 64'd5, 64'd5, 32'd8);
        send_item(rvex_pkg::OpSra, 64'd0, Sign64, 64'hFFC0, 32'd0);
        send_item(rvex_pkg::OpSraiw, 64'd0, 64'h8000_0000, 64'd0, 32'hFFFF_FFFF);
        send_item(rvex_pkg::OpLui, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF);
        send_item(rvex_pkg::OpAuipc, Ones64, 64'd0, 64'd0, 32'h0008_0000);
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 120; i++)
            send_random_item();
        drain_results();
    endtask

    // sender pauses until all results are back, then bursts
    task automatic test_pause_drain();
        for (int i = 0; i < 40; i++)
            send_random_item();
        drain_results();
        for (int i = 0; i < 40; i++)
            send_random_item();
    endtask

    task automatic test_random();
        for (int i = 0; i < 1000; i++)
        begin
            // no idling in the middle stretch
            idle_pct = (i >= 400 && i < 600) ? 0 : 27;
            send_random_item();
        end
    endtask

    // receiver stall
    initial
    begin
        hold_cycles = 0;
        out_stall = 1'b1;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= idle_now();
        end
    end

    // result check
    initial
    begin
        exec_result_t exp_res;
        mismatches = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: value %h redirect %b target %h",
                                 result_value, redirect, target_pc);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (result_value !== exp_res.value || redirect !== exp_res.redir
                        || target_pc !== exp_res.target)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%b/%h got %h/%b/%h",
                                     exp_res.value, exp_res.redir, exp_res.target,
                                     result_value, redirect, target_pc);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        int quiet;
        quiet = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IdleLimit)
            begin
                timed_out = 1'b1;
                $display("** rv64im_execute_unit: FAILED **");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OpLdst;
        inst_pc   = 64'd0;
        src_a     = 64'd0;
        src_b     = 64'd0;
        immediate = 32'sd0;
        idle_pct  = 27;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_pause_drain();
        test_random();
        drain_results();
        repeat (Latency + 10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** rv64im_execute_unit: PASSED **");
        else
            $display("** rv64im_execute_unit: FAILED **");
        $finish;
    end
endmodule
